>>> src/lei_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lei_pkg
// Shared widths, register map and saturation helper for the Lorenz
// Euler integrator.
// ----------------------------------------------------------------------------
package lei_pkg;

    localparam int COORD_W    = 32;
    localparam int DT_W       = 31;
    localparam int CNT_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_W     = 24;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DER_W      = PROD_W - FRAC_W;
    localparam int ACC_W      = 52;

    localparam logic [CFG_ADDR_W-1:0] REG_SIGMA       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BETA        = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RHO         = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TIME_STEP   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_START_X     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_START_Y     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_START_Z     = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_POINT_COUNT = 3'd7;

    localparam logic [COORD_W-1:0] RST_SIGMA       = 32'd167772160;
    localparam logic [COORD_W-1:0] RST_BETA        = 32'd44738124;
    localparam logic [COORD_W-1:0] RST_RHO         = 32'd469762048;
    localparam logic [DT_W-1:0]    RST_TIME_STEP   = 31'd16777;
    localparam logic [COORD_W-1:0] RST_START       = 32'd16777216;
    localparam logic [CNT_W-1:0]   RST_POINT_COUNT = 16'd50000;

    function automatic logic [COORD_W-1:0] sat_coord(input logic [ACC_W-1:0] v);
        logic [ACC_W-COORD_W:0] top;
        top = v[ACC_W-1:COORD_W-1];
        if ((&top) || !(|top)) begin
            return v[COORD_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage
`default_nettype wire

>>> src/lei_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lei_mul
// Shared signed multiplier with a registered full-width product.
// ----------------------------------------------------------------------------
module lei_mul (
    input  wire logic                                aclk,
    input  wire logic signed [lei_pkg::MUL_W-1:0]    a,
    input  wire logic signed [lei_pkg::MUL_W-1:0]    b,
    output logic signed [lei_pkg::PROD_W-1:0]        p_reg
);

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

endmodule
`default_nettype wire

>>> src/lorenz_euler_integrator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lorenz_euler_integrator
// Lorenz attractor point generator, explicit Euler steps in Q8.24.
//
// Input channel (s_): one beat carries s_restart. A restart beat loads the
// position from the start registers and returns point 0; a step beat
// advances the trajectory one Euler step and returns the next point. Steps
// before a restart or past the last point return no beat.
// Output channel (m_): point index, x, y, z and a last flag on the point
// whose index is point_count minus one (a point_count of zero counts as one).
// Config port: cfg_we / cfg_addr / cfg_wdata, to be written only while idle
// by the user; the block does not enforce this. A step runs ten products
// through one shared 33x33 multiplier, one issued per cycle, over the
// compute phases, then the emit state loads the output register; one item
// at a time. The output register lets the next item enter while a point
// waits; a stalled receiver holds the finished point and the block stops
// at its next output load.
// Reset: coefficients and start point return to their defaults, the block
// is idle and waits for a restart.
// ----------------------------------------------------------------------------
module lorenz_euler_integrator (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [lei_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [lei_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_restart,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [lei_pkg::CNT_W-1:0]                 m_point_index,
    output logic signed [lei_pkg::COORD_W-1:0]        m_x_out,
    output logic signed [lei_pkg::COORD_W-1:0]        m_y_out,
    output logic signed [lei_pkg::COORD_W-1:0]        m_z_out,
    output logic                                      m_last
);

    localparam int CW = lei_pkg::COORD_W;
    localparam int MW = lei_pkg::MUL_W;
    localparam int DW = lei_pkg::DER_W;
    localparam int AW = lei_pkg::ACC_W;
    localparam int FW = lei_pkg::FRAC_W;
    localparam int NW = lei_pkg::CNT_W;
    localparam int HI_W = DW - FW;

    localparam logic [3:0] PH_SIG  = 4'd0;
    localparam logic [3:0] PH_RHO  = 4'd1;
    localparam logic [3:0] PH_XY   = 4'd2;
    localparam logic [3:0] PH_BETA = 4'd3;
    localparam logic [3:0] PH_XHI  = 4'd4;
    localparam logic [3:0] PH_XLO  = 4'd5;
    localparam logic [3:0] PH_YHI  = 4'd6;
    localparam logic [3:0] PH_YLO  = 4'd7;
    localparam logic [3:0] PH_ZHI  = 4'd8;
    localparam logic [3:0] PH_ZLO  = 4'd9;
    localparam logic [3:0] PH_LAST = 4'd10;

    typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_EMIT} state_t;

    state_t                 state_reg;
    logic [3:0]             phase_reg;
    logic signed [CW-1:0]   sigma_reg, beta_reg, rho_reg;
    logic signed [CW-1:0]   start_x_reg, start_y_reg, start_z_reg;
    logic [lei_pkg::DT_W-1:0] dt_reg;
    logic [NW-1:0]          count_reg;
    logic signed [CW-1:0]   pos_x_reg, pos_y_reg, pos_z_reg;
    logic [NW-1:0]          idx_reg;
    logic                   running_reg;
    logic signed [DW-1:0]   dx_reg, dy_reg, dz_reg;
    logic signed [AW-1:0]   acc_reg;

    logic                   m_valid_reg, m_last_reg;
    logic [NW-1:0]          m_index_reg;
    logic signed [CW-1:0]   m_x_reg, m_y_reg, m_z_reg;

    logic signed [MW-1:0]               mul_a, mul_b;
    logic signed [lei_pkg::PROD_W-1:0]  prod;
    logic signed [DW-1:0]               prod_sh;
    logic signed [AW-1:0]               prod_low, prod_sh_ext, acc_sum;
    logic signed [DW-1:0]               d_sel;
    logic [NW:0]                        idx_inc, eff_cnt;
    logic                               in_beat, emit_go;

    lei_mul u_mul (
        .aclk  (aclk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (prod)
    );

    assign prod_sh     = prod[lei_pkg::PROD_W-1:FW];
    assign prod_low    = prod[AW-1:0];
    assign prod_sh_ext = {{(AW-DW){prod_sh[DW-1]}}, prod_sh};
    assign acc_sum     = acc_reg + prod_sh_ext;
    assign idx_inc     = {1'b0, idx_reg} + {{NW{1'b0}}, 1'b1};
    assign eff_cnt     = (count_reg == '0) ? {{NW{1'b0}}, 1'b1} : {1'b0, count_reg};
    assign in_beat     = s_valid && s_ready;
    assign emit_go     = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_point_index = m_index_reg;
    assign m_x_out       = m_x_reg;
    assign m_y_out       = m_y_reg;
    assign m_z_out       = m_z_reg;
    assign m_last        = m_last_reg;

    // operand select for the shared multiplier
    always_comb begin
        case (phase_reg)
            PH_XHI, PH_XLO: d_sel = dx_reg;
            PH_YHI, PH_YLO: d_sel = dy_reg;
            default:        d_sel = dz_reg;
        endcase
        case (phase_reg)
            PH_SIG: begin
                mul_a = {sigma_reg[CW-1], sigma_reg};
                mul_b = {pos_y_reg[CW-1], pos_y_reg} - {pos_x_reg[CW-1], pos_x_reg};
            end
            PH_RHO: begin
                mul_a = {pos_x_reg[CW-1], pos_x_reg};
                mul_b = {rho_reg[CW-1], rho_reg} - {pos_z_reg[CW-1], pos_z_reg};
            end
            PH_XY: begin
                mul_a = {pos_x_reg[CW-1], pos_x_reg};
                mul_b = {pos_y_reg[CW-1], pos_y_reg};
            end
            PH_BETA: begin
                mul_a = {beta_reg[CW-1], beta_reg};
                mul_b = {pos_z_reg[CW-1], pos_z_reg};
            end
            PH_XHI, PH_YHI, PH_ZHI: begin
                mul_a = {{(MW-lei_pkg::DT_W){1'b0}}, dt_reg};
                mul_b = {{(MW-HI_W){d_sel[DW-1]}}, d_sel[DW-1:FW]};
            end
            PH_XLO, PH_YLO, PH_ZLO: begin
                mul_a = {{(MW-lei_pkg::DT_W){1'b0}}, dt_reg};
                mul_b = {{(MW-FW){1'b0}}, d_sel[FW-1:0]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_SIG;
            sigma_reg   <= lei_pkg::RST_SIGMA;
            beta_reg    <= lei_pkg::RST_BETA;
            rho_reg     <= lei_pkg::RST_RHO;
            dt_reg      <= lei_pkg::RST_TIME_STEP;
            start_x_reg <= lei_pkg::RST_START;
            start_y_reg <= lei_pkg::RST_START;
            start_z_reg <= lei_pkg::RST_START;
            count_reg   <= lei_pkg::RST_POINT_COUNT;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            pos_z_reg   <= '0;
            idx_reg     <= '0;
            running_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    lei_pkg::REG_SIGMA:       sigma_reg   <= cfg_wdata;
                    lei_pkg::REG_BETA:        beta_reg    <= cfg_wdata;
                    lei_pkg::REG_RHO:         rho_reg     <= cfg_wdata;
                    lei_pkg::REG_TIME_STEP:   dt_reg      <= cfg_wdata[lei_pkg::DT_W-1:0];
                    lei_pkg::REG_START_X:     start_x_reg <= cfg_wdata;
                    lei_pkg::REG_START_Y:     start_y_reg <= cfg_wdata;
                    lei_pkg::REG_START_Z:     start_z_reg <= cfg_wdata;
                    lei_pkg::REG_POINT_COUNT: count_reg   <= cfg_wdata[NW-1:0];
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready && !emit_go) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        if (s_restart) begin
                            pos_x_reg   <= start_x_reg;
                            pos_y_reg   <= start_y_reg;
                            pos_z_reg   <= start_z_reg;
                            idx_reg     <= '0;
                            running_reg <= 1'b1;
                            state_reg   <= ST_EMIT;
                        end else if (running_reg) begin
                            if (idx_inc >= eff_cnt) begin
                                running_reg <= 1'b0;
                            end else begin
                                phase_reg <= PH_SIG;
                                state_reg <= ST_CALC;
                            end
                        end
                    end
                end
                ST_CALC: begin
                    phase_reg <= phase_reg + 4'd1;
                    case (phase_reg)
                        PH_RHO:  dx_reg  <= prod_sh;
                        PH_XY:   dy_reg  <= prod_sh - {{(DW-CW){pos_y_reg[CW-1]}}, pos_y_reg};
                        PH_BETA: dz_reg  <= prod_sh;
                        PH_XHI:  dz_reg  <= dz_reg - prod_sh;
                        PH_XLO:  acc_reg <= {{(AW-CW){pos_x_reg[CW-1]}}, pos_x_reg} + prod_low;
                        PH_YHI:  pos_x_reg <= lei_pkg::sat_coord(acc_sum);
                        PH_YLO:  acc_reg <= {{(AW-CW){pos_y_reg[CW-1]}}, pos_y_reg} + prod_low;
                        PH_ZHI:  pos_y_reg <= lei_pkg::sat_coord(acc_sum);
                        PH_ZLO:  acc_reg <= {{(AW-CW){pos_z_reg[CW-1]}}, pos_z_reg} + prod_low;
                        PH_LAST: begin
                            pos_z_reg <= lei_pkg::sat_coord(acc_sum);
                            idx_reg   <= idx_inc[NW-1:0];
                            state_reg <= ST_EMIT;
                        end
                        default: ;
                    endcase
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        m_valid_reg <= 1'b1;
                        m_index_reg <= idx_reg;
                        m_x_reg     <= pos_x_reg;
                        m_y_reg     <= pos_y_reg;
                        m_z_reg     <= pos_z_reg;
                        m_last_reg  <= (idx_inc == eff_cnt);
                        if (idx_inc == eff_cnt) begin
                            running_reg <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // a new point beat only follows an output load
    a_load_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_EMIT))
        else $error("output beat without emit state");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) |-> (phase_reg <= PH_LAST))
        else $error("phase counter overran");

    a_idle_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && !s_restart && !running_reg) |=> (state_reg == ST_IDLE) && !running_reg)
        else $error("idle step left idle");

    a_last_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last && state_reg == ST_IDLE) |-> !running_reg)
        else $error("trajectory still running after last point");

    a_calc_ends_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC && phase_reg == PH_LAST) |=> (state_reg == ST_EMIT))
        else $error("step did not reach emit");

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Lorenz Euler integrator. A queue-fed driver
// offers restart and step beats, a shadow trajectory predicts every point in
// Q8.24 at full precision, and the monitor compares each output beat field
// by field. Coefficients, time step, start point and point count change
// between phases, covering saturation, trajectory end and restart cases.
// ----------------------------------------------------------------------------
module testbench;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [lei_pkg::CNT_W-1:0]          index;
        logic signed [lei_pkg::COORD_W-1:0] x;
        logic signed [lei_pkg::COORD_W-1:0] y;
        logic signed [lei_pkg::COORD_W-1:0] z;
        logic                               is_last;
    } point_t;

    localparam logic ITEM_RESTART = 1'b1;
    localparam logic ITEM_STEP    = 1'b0;

    localparam wide_t COORD_MAX     = 128'sd2147483647;
    localparam wide_t COORD_MIN     = -128'sd2147483648;
    localparam int    SETTLE_CYCLES = 20;
    localparam int    LONG_HOLD     = 300;
    localparam int    ITEM_TARGET   = 1050;
    localparam int    CYCLE_LIMIT   = 500000;

    logic                               aclk;
    logic                               aresetn   = 1'b0;
    logic                               cfg_we    = 1'b0;
    logic [lei_pkg::CFG_ADDR_W-1:0]     cfg_addr  = '0;
    logic [lei_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;
    logic                               s_valid   = 1'b0;
    logic                               s_ready;
    logic                               s_restart = 1'b0;
    logic                               m_valid;
    logic                               m_ready   = 1'b0;
    logic [lei_pkg::CNT_W-1:0]          m_point_index;
    logic signed [lei_pkg::COORD_W-1:0] m_x_out;
    logic signed [lei_pkg::COORD_W-1:0] m_y_out;
    logic signed [lei_pkg::COORD_W-1:0] m_z_out;
    logic                               m_last;

    // shadow copy of the register file
    logic signed [lei_pkg::COORD_W-1:0] cfg_sigma   = lei_pkg::RST_SIGMA;
    logic signed [lei_pkg::COORD_W-1:0] cfg_beta    = lei_pkg::RST_BETA;
    logic signed [lei_pkg::COORD_W-1:0] cfg_rho     = lei_pkg::RST_RHO;
    logic [lei_pkg::DT_W-1:0]           cfg_dt      = lei_pkg::RST_TIME_STEP;
    logic signed [lei_pkg::COORD_W-1:0] cfg_start_x = lei_pkg::RST_START;
    logic signed [lei_pkg::COORD_W-1:0] cfg_start_y = lei_pkg::RST_START;
    logic signed [lei_pkg::COORD_W-1:0] cfg_start_z = lei_pkg::RST_START;
    logic [lei_pkg::CNT_W-1:0]          cfg_count   = lei_pkg::RST_POINT_COUNT;

    // shadow trajectory state
    logic signed [lei_pkg::COORD_W-1:0] traj_x    = '0;
    logic signed [lei_pkg::COORD_W-1:0] traj_y    = '0;
    logic signed [lei_pkg::COORD_W-1:0] traj_z    = '0;
    logic [lei_pkg::CNT_W-1:0]          traj_idx  = '0;
    logic                               traj_live = 1'b0;

    logic   pending_items[$];
    point_t expected_points[$];

    int errors        = 0;
    int cycles        = 0;
    int sent_items    = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int stall_left    = 0;
    int send_gap      = 0;
    bit quiet         = 1'b0;
    bit in_taken      = 1'b0;

    lorenz_euler_integrator DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_index (m_point_index),
        .m_x_out       (m_x_out),
        .m_y_out       (m_y_out),
        .m_z_out       (m_z_out),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic signed [lei_pkg::COORD_W-1:0] clamp_coord(input wide_t v);
        if (v > COORD_MAX) begin
            return COORD_MAX[lei_pkg::COORD_W-1:0];
        end else if (v < COORD_MIN) begin
            return COORD_MIN[lei_pkg::COORD_W-1:0];
        end
        return v[lei_pkg::COORD_W-1:0];
    endfunction

    // floor(dt * d / 2^24), exact
    function automatic wide_t dt_scale(input wide_t d);
        wide_t w_dt;
        w_dt = cfg_dt;
        return (w_dt * d) >>> lei_pkg::FRAC_W;
    endfunction

    task automatic record_point(input int limit);
        point_t p;
        p.index   = traj_idx;
        p.x       = traj_x;
        p.y       = traj_y;
        p.z       = traj_z;
        p.is_last = (int'(traj_idx) + 1 == limit);
        if (p.is_last) begin
            traj_live = 1'b0;
        end
        expected_points.push_back(p);
    endtask

    task automatic advance_trajectory(input logic restart);
        wide_t x, y, z, s, b, r, dx, dy, dz;
        int    limit;
        limit = (cfg_count == 0) ? 1 : int'(cfg_count);
        if (restart == ITEM_RESTART) begin
            traj_x    = cfg_start_x;
            traj_y    = cfg_start_y;
            traj_z    = cfg_start_z;
            traj_idx  = '0;
            traj_live = 1'b1;
            record_point(limit);
        end else if (traj_live) begin
            if (int'(traj_idx) + 1 >= limit) begin
                traj_live = 1'b0;
            end else begin
                x  = traj_x;
                y  = traj_y;
                z  = traj_z;
                s  = cfg_sigma;
                b  = cfg_beta;
                r  = cfg_rho;
                dx = (s * (y - x)) >>> lei_pkg::FRAC_W;
                dy = ((x * (r - z)) >>> lei_pkg::FRAC_W) - y;
                dz = ((x * y) >>> lei_pkg::FRAC_W) - ((b * z) >>> lei_pkg::FRAC_W);
                traj_x   = clamp_coord(x + dt_scale(dx));
                traj_y   = clamp_coord(y + dt_scale(dy));
                traj_z   = clamp_coord(z + dt_scale(dz));
                traj_idx = traj_idx + 1'b1;
                record_point(limit);
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    task automatic check_point();
        point_t want;
        if (expected_points.size() == 0) begin
            errors++;
            $display("%0t: point beat expected none actual index %0d", $time,
                     m_point_index);
        end else begin
            want = expected_points.pop_front();
            compare_field("point_index", want.index, m_point_index);
            compare_field("x_out", want.x, m_x_out);
            compare_field("y_out", want.y, m_y_out);
            compare_field("z_out", want.z, m_z_out);
            compare_field("last", want.is_last, m_last);
        end
    endtask

    // monitor: prediction on input beats, checking on output beats
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            in_taken <= aresetn && s_valid && s_ready;
            if (aresetn && s_valid && s_ready) begin
                sent_items++;
                advance_trajectory(s_restart);
            end
            if (aresetn && m_valid && m_ready) begin
                check_point();
            end
        end
    end

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (send_gap == 0 && !quiet && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(1, 8);
            end
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                s_valid   <= 1'b1;
                s_restart <= pending_items.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [lei_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [lei_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        case (idx)
            lei_pkg::REG_SIGMA:       cfg_sigma   = data;
            lei_pkg::REG_BETA:        cfg_beta    = data;
            lei_pkg::REG_RHO:         cfg_rho     = data;
            lei_pkg::REG_TIME_STEP:   cfg_dt      = data[lei_pkg::DT_W-1:0];
            lei_pkg::REG_START_X:     cfg_start_x = data;
            lei_pkg::REG_START_Y:     cfg_start_y = data;
            lei_pkg::REG_START_Z:     cfg_start_z = data;
            lei_pkg::REG_POINT_COUNT: cfg_count   = data[lei_pkg::CNT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (pending_items.size() != 0 || s_valid || expected_points.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_coeff();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 5))
            0:       return raw;
            1:       return raw[0] ? 32'h7fff_ffff : 32'h8000_0000;
            default: return {{4{raw[27]}}, raw[27:0]};
        endcase
    endfunction

    initial begin
        int phase;
        int n_steps;
        int span;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // defaults, step while idle, short run
        pending_items.push_back(ITEM_STEP);
        pending_items.push_back(ITEM_RESTART);
        repeat (5) pending_items.push_back(ITEM_STEP);
        wait_for_drain();

        // extremes, saturation, steps past the end
        write_reg(lei_pkg::REG_SIGMA, 32'h7fff_ffff);
        write_reg(lei_pkg::REG_BETA, 32'h8000_0000);
        write_reg(lei_pkg::REG_RHO, 32'h8000_0000);
        write_reg(lei_pkg::REG_TIME_STEP, 32'h7fff_ffff);
        write_reg(lei_pkg::REG_START_X, 32'h7fff_ffff);
        write_reg(lei_pkg::REG_START_Y, 32'h8000_0000);
        write_reg(lei_pkg::REG_START_Z, 32'h7fff_ffff);
        write_reg(lei_pkg::REG_POINT_COUNT, 32'd3);
        pending_items.push_back(ITEM_RESTART);
        repeat (4) pending_items.push_back(ITEM_STEP);
        wait_for_drain();

        // opposite extremes, zero point count
        write_reg(lei_pkg::REG_SIGMA, 32'h8000_0000);
        write_reg(lei_pkg::REG_BETA, 32'h7fff_ffff);
        write_reg(lei_pkg::REG_RHO, 32'h7fff_ffff);
        write_reg(lei_pkg::REG_START_X, 32'h8000_0000);
        write_reg(lei_pkg::REG_START_Y, 32'h7fff_ffff);
        write_reg(lei_pkg::REG_START_Z, 32'h8000_0000);
        write_reg(lei_pkg::REG_POINT_COUNT, 32'd0);
        pending_items.push_back(ITEM_RESTART);
        pending_items.push_back(ITEM_STEP);
        wait_for_drain();
        write_reg(lei_pkg::REG_POINT_COUNT, 32'd1);
        pending_items.push_back(ITEM_RESTART);
        pending_items.push_back(ITEM_STEP);
        wait_for_drain();

        // zero time step, restart while running
        write_reg(lei_pkg::REG_TIME_STEP, 32'd0);
        write_reg(lei_pkg::REG_POINT_COUNT, 32'd10);
        pending_items.push_back(ITEM_RESTART);
        pending_items.push_back(ITEM_STEP);
        pending_items.push_back(ITEM_STEP);
        pending_items.push_back(ITEM_RESTART);
        pending_items.push_back(ITEM_STEP);
        wait_for_drain();

        // point count lowered so the running index is the last point
        write_reg(lei_pkg::REG_POINT_COUNT, 32'd2);
        pending_items.push_back(ITEM_STEP);
        pending_items.push_back(ITEM_STEP);
        wait_for_drain();

        phase = 0;
        while (sent_items < ITEM_TARGET) begin
            if (sent_items > ITEM_TARGET - 150) begin
                quiet = 1'b1;
            end
            write_reg(lei_pkg::REG_SIGMA, pick_coeff());
            write_reg(lei_pkg::REG_BETA, pick_coeff());
            write_reg(lei_pkg::REG_RHO, pick_coeff());
            case ($urandom_range(0, 5))
                0:       write_reg(lei_pkg::REG_TIME_STEP, $urandom);
                1:       write_reg(lei_pkg::REG_TIME_STEP, 32'd0);
                default: write_reg(lei_pkg::REG_TIME_STEP, $urandom_range(1, 1 << 20));
            endcase
            write_reg(lei_pkg::REG_START_X, pick_coeff());
            write_reg(lei_pkg::REG_START_Y, pick_coeff());
            write_reg(lei_pkg::REG_START_Z, pick_coeff());
            case ($urandom_range(0, 19))
                0:       write_reg(lei_pkg::REG_POINT_COUNT, 32'd0);
                1:       write_reg(lei_pkg::REG_POINT_COUNT, 32'd65535);
                2:       write_reg(lei_pkg::REG_POINT_COUNT, $urandom_range(1, 65535));
                3, 4:    write_reg(lei_pkg::REG_POINT_COUNT, $urandom_range(41, 120));
                default: write_reg(lei_pkg::REG_POINT_COUNT, $urandom_range(1, 40));
            endcase
            // long receiver hold while beats keep coming
            if (phase == 1 || phase == 7) begin
                write_reg(lei_pkg::REG_POINT_COUNT, 32'd200);
                hold_requests++;
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) pending_items.push_back(ITEM_STEP);
            end
            pending_items.push_back(ITEM_RESTART);
            span = (cfg_count > 60) ? 62 : int'(cfg_count) + 2;
            n_steps = (phase == 1 || phase == 7) ? 40 : $urandom_range(0, span);
            repeat (n_steps) begin
                if ($urandom_range(0, 29) == 0) begin
                    pending_items.push_back(ITEM_RESTART);
                end else begin
                    pending_items.push_back(ITEM_STEP);
                end
            end
            wait_for_drain();
            phase++;
        end

        if (errors == 0 && expected_points.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
